@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/sgra_pkg.sv @@
// ----------------------------------------------------------------------------
// sgra_pkg
// Types and constants of the sparse GF(2) row adder.
// ----------------------------------------------------------------------------
`default_nettype none

package sgra_pkg;

   localparam int ROW_CAPACITY_DEFAULT = 255;
   localparam int FUNC_W  = 3;
   localparam int COL_W   = 32;
   localparam int POS_W   = 8;
   localparam int LEN_W   = 8;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W = COL_W + POS_W;
   localparam int RSP_DATA_W = COL_W + LEN_W;

   typedef enum logic [FUNC_W-1:0] {
      FN_CLEAR      = 3'd0,
      FN_APPEND_SRC = 3'd1,
      FN_APPEND_TGT = 3'd2,
      FN_ADD        = 3'd3,
      FN_LENGTH     = 3'd4,
      FN_READ       = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_OVER   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/sgra_ram.sv @@
// ----------------------------------------------------------------------------
// sgra_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 255,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/sparse_gf2_row_adder.sv @@
// ----------------------------------------------------------------------------
// sparse_gf2_row_adder
// Holds a source row and a double-buffered target row of ascending column
// indices and adds the source into the target over GF(2) with a merge walk.
//
//   Channel   Direction   Content
//   req_*     in          tuser: func; tdata: column_index, position
//   rsp_*     out         tuser: status; tdata: read_value, row_length
//
// Clear, append and unused codes go from idle straight to the finish step; a
// read passes the read step first. Add and length query run the merge walk in
// the walk step, which reads one element per cycle from each row memory.
// Reset clears the counts and the bank select; the row memories keep content.
// A new transaction is taken while the previous result waits on rsp; the
// next result then waits in the finish step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sparse_gf2_row_adder #(
   parameter int ROW_CAPACITY = sgra_pkg::ROW_CAPACITY_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [2:0] func
   input  wire logic [sgra_pkg::FUNC_W-1:0]     req_tuser,
   // [31:0] column_index, [39:32] position
   input  wire logic [sgra_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [1:0] status
   output logic      [sgra_pkg::STAT_W-1:0]     rsp_tuser,
   // [31:0] read_value, [39:32] row_length
   output logic      [sgra_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import sgra_pkg::*;

   localparam int CNT_W = $clog2(ROW_CAPACITY + 1);
   localparam int IDX_W = $clog2(ROW_CAPACITY);
   localparam int N_W   = $clog2(2 * ROW_CAPACITY + 1);
   localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LW    = (N_W > LEN_W) ? N_W : LEN_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(ROW_CAPACITY);
   localparam logic [N_W-1:0]   CAP_N   = N_W'(ROW_CAPACITY);

   state_type        state_ff, state_in;
   func_type         op_ff, op_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0] ks_ff, ks_in;
   logic [CNT_W-1:0] kt_ff, kt_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] src_cnt_ff, src_cnt_in;
   logic [CNT_W-1:0] tgt_cnt_ff, tgt_cnt_in;
   logic             bank_ff, bank_in;
   logic [COL_W-1:0] res_value_ff, res_value_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   status_type       rsp_status_ff, rsp_status_in;

   func_type         req_func;
   logic [COL_W-1:0] req_col;
   logic [PW-1:0]    req_pos;

   logic             src_we;
   logic [IDX_W-1:0] src_wr_addr;
   logic [IDX_W-1:0] src_rd_addr;
   logic [COL_W-1:0] src_rd_data;
   logic             tgt_we_a;
   logic             tgt_we_b;
   logic [IDX_W-1:0] tgt_wr_addr;
   logic [COL_W-1:0] tgt_wr_data;
   logic [IDX_W-1:0] tgt_rd_addr;
   logic [COL_W-1:0] tgt_a_rd_data;
   logic [COL_W-1:0] tgt_b_rd_data;
   logic [COL_W-1:0] tgt_val;

   logic [LW-1:0]    tgt_len_w;
   logic [LW-1:0]    tgt_len_p1_w;
   logic [LW-1:0]    n_len_w;
   logic [CNT_W-1:0] tgt_cnt_p1;
   logic             s_has;
   logic             t_has;
   logic             take_s;
   logic             take_t;
   logic             cancel;
   logic             rsp_free;

   assign req_func = func_type'(req_tuser);
   assign req_col  = req_tdata[COL_W-1:0];
   assign req_pos  = PW'(req_tdata[REQ_DATA_W-1:COL_W]);

   assign tgt_val      = bank_ff ? tgt_b_rd_data : tgt_a_rd_data;
   assign tgt_cnt_p1   = tgt_cnt_ff + 1'b1;
   assign tgt_len_w    = LW'(tgt_cnt_ff);
   assign tgt_len_p1_w = LW'(tgt_cnt_p1);
   assign n_len_w      = LW'(n_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   assign s_has  = ks_ff < src_cnt_ff;
   assign t_has  = kt_ff < tgt_cnt_ff;
   assign take_s = s_has && (!t_has || (src_rd_data < tgt_val));
   assign take_t = t_has && (!s_has || (tgt_val < src_rd_data));
   assign cancel = s_has && t_has && (src_rd_data == tgt_val);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      ks_in         = ks_ff;
      kt_in         = kt_ff;
      n_in          = n_ff;
      src_cnt_in    = src_cnt_ff;
      tgt_cnt_in    = tgt_cnt_ff;
      bank_in       = bank_ff;
      res_value_in  = res_value_ff;
      res_len_in    = res_len_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;
      src_we        = 1'b0;
      src_wr_addr   = src_cnt_ff[IDX_W-1:0];
      tgt_we_a      = 1'b0;
      tgt_we_b      = 1'b0;
      tgt_wr_addr   = tgt_cnt_ff[IDX_W-1:0];
      tgt_wr_data   = req_col;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ks_in      = '0;
            kt_in      = '0;
            if (req_tvalid) begin
               op_in         = req_func;
               pos_in        = req_pos;
               n_in          = '0;
               res_value_in  = '0;
               res_status_in = STAT_OK;
               res_len_in    = tgt_len_w[LEN_W-1:0];
               state_in      = ST_FINISH;
               unique case (req_func)
                  FN_CLEAR: begin
                     src_cnt_in = '0;
                     tgt_cnt_in = '0;
                     res_len_in = '0;
                  end
                  FN_APPEND_SRC: begin
                     if (src_cnt_ff < CAP_CNT) begin
                        src_we     = 1'b1;
                        src_cnt_in = src_cnt_ff + 1'b1;
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  FN_APPEND_TGT: begin
                     if (tgt_cnt_ff < CAP_CNT) begin
                        tgt_we_a   = !bank_ff;
                        tgt_we_b   = bank_ff;
                        tgt_cnt_in = tgt_cnt_p1;
                        res_len_in = tgt_len_p1_w[LEN_W-1:0];
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  FN_ADD, FN_LENGTH: begin
                     state_in = ST_WALK;
                  end
                  FN_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!s_has && !t_has) begin
               state_in = ST_FINISH;
               if (n_ff > CAP_N) begin
                  res_status_in = STAT_OVER;
                  res_len_in    = tgt_len_w[LEN_W-1:0];
               end else begin
                  res_status_in = STAT_OK;
                  res_len_in    = n_len_w[LEN_W-1:0];
                  if (op_ff == FN_ADD) begin
                     bank_in    = !bank_ff;
                     tgt_cnt_in = CNT_W'(n_ff);
                  end
               end
            end else begin
               tgt_wr_addr = n_ff[IDX_W-1:0];
               tgt_wr_data = take_s ? src_rd_data : tgt_val;
               if ((take_s || take_t) && (n_ff < CAP_N) && (op_ff == FN_ADD)) begin
                  tgt_we_a = bank_ff;
                  tgt_we_b = !bank_ff;
               end
               if (take_s || take_t) begin
                  n_in = n_ff + 1'b1;
               end
               if (take_s || cancel) begin
                  ks_in = ks_ff + 1'b1;
               end
               if (take_t || cancel) begin
                  kt_in = kt_ff + 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in   = ST_FINISH;
            res_len_in = tgt_len_w[LEN_W-1:0];
            if (pos_ff < PW'(tgt_cnt_ff)) begin
               res_value_in  = tgt_val;
               res_status_in = STAT_OK;
            end else begin
               res_value_in  = '0;
               res_status_in = STAT_BADPOS;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_len_in    = res_len_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      src_rd_addr = ks_in[IDX_W-1:0];
      if ((state_ff == ST_IDLE) && (req_func == FN_READ)) begin
         tgt_rd_addr = req_pos[IDX_W-1:0];
      end else begin
         tgt_rd_addr = kt_in[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_cnt_ff   <= '0;
         tgt_cnt_ff   <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_cnt_ff   <= src_cnt_in;
         tgt_cnt_ff   <= tgt_cnt_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      ks_ff         <= ks_in;
      kt_ff         <= kt_in;
      n_ff          <= n_in;
      res_value_ff  <= res_value_in;
      res_len_ff    <= res_len_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   sgra_ram #(
      .WIDTH (COL_W),
      .DEPTH (ROW_CAPACITY)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_wr_addr),
      .wr_data (req_col),
      .rd_addr (src_rd_addr),
      .rd_data (src_rd_data)
   );

   sgra_ram #(
      .WIDTH (COL_W),
      .DEPTH (ROW_CAPACITY)
   ) u_tgt_a_ram (
      .clock   (clock),
      .wr_en   (tgt_we_a),
      .wr_addr (tgt_wr_addr),
      .wr_data (tgt_wr_data),
      .rd_addr (tgt_rd_addr),
      .rd_data (tgt_a_rd_data)
   );

   sgra_ram #(
      .WIDTH (COL_W),
      .DEPTH (ROW_CAPACITY)
   ) u_tgt_b_ram (
      .clock   (clock),
      .wr_en   (tgt_we_b),
      .wr_addr (tgt_wr_addr),
      .wr_data (tgt_wr_data),
      .rd_addr (tgt_rd_addr),
      .rd_data (tgt_b_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_value_ff};

   `ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, (src_cnt_ff <= CAP_CNT) && (tgt_cnt_ff <= CAP_CNT))
   `ASSERT_IMPLY(a_walk_range, clock, reset, state_ff == ST_WALK, (ks_ff <= src_cnt_ff) && (kt_ff <= tgt_cnt_ff))
   `ASSERT_NEXT(a_bank_in_walk, clock, reset, state_ff != ST_WALK, bank_ff == $past(bank_ff))

endmodule

`default_nettype wire

@@ bench/row_adder_checker.sv @@
// ----------------------------------------------------------------------------
// row_adder_checker
// Watches both streams of the sparse GF(2) row adder. It keeps its own copy of
// the source row, the double-buffered target row and the counts, predicts the
// result of every accepted request and compares each accepted response with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_adder_checker #(
   parameter int CAPACITY = sgra_pkg::ROW_CAPACITY_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [sgra_pkg::FUNC_W-1:0]     req_tuser,
   input  wire logic [sgra_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [sgra_pkg::STAT_W-1:0]     rsp_tuser,
   input  wire logic [sgra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                   mismatches,
   output int                                   outstanding
);

   import sgra_pkg::*;

   typedef struct packed {
      logic [COL_W-1:0] read_value;
      logic [LEN_W-1:0] row_length;
      status_type       status;
   } row_result_type;

   logic [COL_W-1:0] source_row [CAPACITY];
   logic [COL_W-1:0] target_row [2][CAPACITY];
   int               source_len;
   int               target_len;
   bit               bank_sel;
   int               fail_count;
   row_result_type   expected_results [$];

   initial begin
      mismatches = 0;
      outstanding = 0;
      fail_count = 0;
   end

   // Ordered merge of both rows in which equal indices cancel. With commit set
   // the merged row is written into the bank that is not in use.
   function automatic int merge_rows(input bit commit);
      int ks;
      int kt;
      int n;
      logic [COL_W-1:0] a;
      logic [COL_W-1:0] b;
      ks = 0;
      kt = 0;
      n = 0;
      while (ks < source_len && kt < target_len) begin
         a = source_row[ks];
         b = target_row[bank_sel][kt];
         if (a < b) begin
            if (commit) target_row[!bank_sel][n] = a;
            n++;
            ks++;
         end else if (a > b) begin
            if (commit) target_row[!bank_sel][n] = b;
            n++;
            kt++;
         end else begin
            ks++;
            kt++;
         end
      end
      while (ks < source_len) begin
         if (commit) target_row[!bank_sel][n] = source_row[ks];
         n++;
         ks++;
      end
      while (kt < target_len) begin
         if (commit) target_row[!bank_sel][n] = target_row[bank_sel][kt];
         n++;
         kt++;
      end
      return n;
   endfunction

   function automatic row_result_type predict_row_op(input logic [FUNC_W-1:0] f,
                                                     input logic [COL_W-1:0] col,
                                                     input logic [POS_W-1:0] pos);
      row_result_type r;
      int n;
      r.read_value = '0;
      r.status = STAT_OK;
      n = 0;
      case (f)
         FN_CLEAR: begin
            source_len = 0;
            target_len = 0;
         end
         FN_APPEND_SRC: begin
            if (source_len >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               source_row[source_len] = col;
               source_len++;
            end
         end
         FN_APPEND_TGT: begin
            if (target_len >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               target_row[bank_sel][target_len] = col;
               target_len++;
            end
         end
         FN_ADD, FN_LENGTH: begin
            n = merge_rows(1'b0);
            if (n > CAPACITY) begin
               r.status = STAT_OVER;
               n = target_len;
            end else if (f == FN_ADD) begin
               void'(merge_rows(1'b1));
               bank_sel = !bank_sel;
               target_len = n;
            end
         end
         FN_READ: begin
            if (pos < target_len && pos < CAPACITY)
               r.read_value = target_row[bank_sel][pos];
            else r.status = STAT_BADPOS;
         end
         default: ;
      endcase
      if (f != FN_ADD && f != FN_LENGTH) n = target_len;
      r.row_length = n[LEN_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      row_result_type got;
      row_result_type want;
      if (reset) begin
         source_len = 0;
         target_len = 0;
         bank_sel = 1'b0;
         expected_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_value = rsp_tdata[COL_W-1:0];
            got.row_length = rsp_tdata[RSP_DATA_W-1:COL_W];
            got.status = status_type'(rsp_tuser);
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no pending transaction: %s %h %0d %0d",
                           $realtime, "value, length, status", got.read_value,
                           got.row_length, got.status);
            end else begin
               want = expected_results.pop_front();
               if (got.read_value !== want.read_value || got.row_length !== want.row_length ||
                   got.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected value %h length %0d status %0d, ",
                               "got value %h length %0d status %0d"},
                              $realtime, want.read_value, want.row_length, want.status,
                              got.read_value, got.row_length, got.status);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_row_op(req_tuser, req_tdata[COL_W-1:0],
                                                      req_tdata[REQ_DATA_W-1:COL_W]));
         outstanding <= expected_results.size();
      end
      mismatches <= fail_count;
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the sparse GF(2) row adder. A short directed run covers the
// field extremes, every operation, bad positions, unsorted appends and unused
// codes. Random merge sequences with overlapping rows follow, with bursty requests
// and a stalling response side; full rows and over-long merges come midway. The
// checker compares every response and hands its failure count to this module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import sgra_pkg::*;

   localparam int CAPACITY    = ROW_CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 1300;
   localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STAT_W-1:0]     rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatches;
   int                    outstanding;
   int                    items_sent = 0;
   int                    burst_left = 0;
   int                    cycles = 0;
   logic [1:0]            stall_mode = 2'd0;

   sparse_gf2_row_adder #(.ROW_CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   row_adder_checker #(.CAPACITY(CAPACITY)) row_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (cycles % 200 == 0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (cycles % 5) < 2;
         default: rsp_tready <= (cycles % 24) >= 16;
      endcase
   end

   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [COL_W-1:0] col,
                               input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {pos, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (f <= FN_READ) items_sent++;
   endtask

   initial begin
      logic [COL_W-1:0] src_vals [$];
      logic [COL_W-1:0] tgt_vals [$];
      logic [COL_W:0]   cand;
      logic [COL_W-1:0] v;
      int               mode;
      int               pick;
      int               n_cand;
      int               ops;
      bit               big_done;
      big_done = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(FN_CLEAR, 32'h0, 8'h0);
      send_request(FN_READ, 32'hFFFF_FFFF, 8'h0);
      send_request(FN_LENGTH, 32'h0, 8'hFF);
      send_request(FN_APPEND_SRC, 32'h0, 8'h0);
      send_request(FN_APPEND_SRC, 32'hFFFF_FFFF, 8'hFF);
      send_request(FN_APPEND_TGT, 32'h0, 8'h0);
      send_request(FN_APPEND_TGT, 32'h7, 8'h0);
      send_request(FN_LENGTH, 32'h0, 8'h0);
      send_request(FN_ADD, 32'h0, 8'h0);
      send_request(FN_READ, 32'h0, 8'd0);
      send_request(FN_READ, 32'h0, 8'd1);
      send_request(FN_READ, 32'h0, 8'd2);
      send_request(FN_READ, 32'h0, 8'hFF);
      send_request(FN_UNUSED_A, 32'hFFFF_FFFF, 8'hFF);
      send_request(FN_UNUSED_B, 32'h0, 8'h0);
      send_request(FN_APPEND_SRC, 32'h9, 8'h0);
      send_request(FN_APPEND_SRC, 32'h3, 8'h0);
      send_request(FN_ADD, 32'h0, 8'h0);
      send_request(FN_READ, 32'h0, 8'd0);
      send_request(FN_READ, 32'h0, 8'd3);
      send_request(FN_ADD, 32'h0, 8'h0);
      send_request(FN_LENGTH, 32'h0, 8'h0);
      send_request(FN_CLEAR, 32'hFFFF_FFFF, 8'hFF);

      while (items_sent < ITEM_TARGET) begin
         if (!big_done && items_sent >= ITEM_TARGET / 2) begin
            // Fill the source to capacity, then drive the merge to exactly
            // capacity and one past it.
            big_done = 1'b1;
            send_request(FN_CLEAR, $urandom, POS_W'($urandom));
            for (int i = 0; i <= CAPACITY; i++)
               send_request(FN_APPEND_SRC, COL_W'(2 * i), POS_W'($urandom));
            send_request(FN_LENGTH, $urandom, POS_W'($urandom));
            send_request(FN_ADD, $urandom, POS_W'($urandom));
            send_request(FN_READ, $urandom, POS_W'(CAPACITY - 1));
            send_request(FN_READ, $urandom, POS_W'(CAPACITY));
            send_request(FN_APPEND_TGT, 32'h1, POS_W'($urandom));
            send_request(FN_ADD, $urandom, POS_W'($urandom));
            send_request(FN_APPEND_TGT, 32'h1, POS_W'($urandom));
            send_request(FN_LENGTH, $urandom, POS_W'($urandom));
            send_request(FN_ADD, $urandom, POS_W'($urandom));
            send_request(FN_READ, $urandom, 8'd0);
            send_request(FN_CLEAR, $urandom, POS_W'($urandom));
         end

         if ($urandom_range(0, 3) != 0) send_request(FN_CLEAR, $urandom, POS_W'($urandom));
         mode = $urandom_range(0, 3);
         src_vals.delete();
         tgt_vals.delete();
         n_cand = $urandom_range(0, 14);
         case (mode)
            0: cand = $urandom_range(0, 4);
            1: cand = $urandom_range(0, 32'h0FFF_FFFF);
            2: cand = 33'h0_FFFF_FFFF - $urandom_range(0, 40);
            default: cand = '0;
         endcase
         for (int i = 0; i < n_cand; i++) begin
            if (mode == 3) cand = {1'b0, $urandom()};
            if (cand[COL_W]) break;
            pick = $urandom_range(0, 3);
            if (pick == 0 || pick == 2) src_vals.push_back(cand[COL_W-1:0]);
            if (pick == 1 || pick == 2) tgt_vals.push_back(cand[COL_W-1:0]);
            case (mode)
               0: cand = cand + $urandom_range(1, 2);
               1: cand = cand + ($urandom() >> $urandom_range(3, 31)) + 1;
               2: cand = cand + $urandom_range(1, 3);
               default: ;
            endcase
         end

         while (src_vals.size() + tgt_vals.size() > 0) begin
            if (tgt_vals.size() == 0 || (src_vals.size() > 0 && $urandom_range(0, 1) == 1)) begin
               v = src_vals.pop_front();
               send_request(FN_APPEND_SRC, v, POS_W'($urandom));
            end else begin
               v = tgt_vals.pop_front();
               send_request(FN_APPEND_TGT, v, POS_W'($urandom));
            end
         end

         ops = $urandom_range(1, 4);
         for (int i = 0; i < ops; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
               send_request(FN_ADD, $urandom, POS_W'($urandom));
            else if (pick < 6)
               send_request(FN_LENGTH, $urandom, POS_W'($urandom));
            else if (pick < 9)
               send_request(FN_READ, $urandom, POS_W'(($urandom_range(0, 7) == 0) ?
                            $urandom_range(0, 255) : $urandom_range(0, 20)));
            else
               send_request(($urandom_range(0, 1) == 1) ? FN_UNUSED_A : FN_UNUSED_B,
                            $urandom, POS_W'($urandom));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
